>>> rtl/flux_pulse_to_bitcell_quantizer_macros.svh
// Assertion macros for the flux pulse to bit cell quantizer.
// Used by the top level and by the divider; no other dependencies.
`ifndef FLUX_PULSE_TO_BITCELL_QUANTIZER_MACROS_SVH
`define FLUX_PULSE_TO_BITCELL_QUANTIZER_MACROS_SVH
`ifndef SYNTHESIS
`define FPTBQ_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fptbq check failed");
`define FPTBQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fptbq check failed");
`else
`define FPTBQ_ASSERT_HOLDS(label, clk, rst_n, cond)
`define FPTBQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/fptbq_pkg.sv
// Package for the flux pulse to bit cell quantizer: widths, codes and divider types.
// No dependencies; used by fptbq_if, the divider, the top level and the testbench.
`timescale 1ns / 1ps

package fptbq_pkg;

    localparam int MaxPulses = 65536;

    localparam int TimeW  = 24;
    localparam int ByteW  = 8;
    localparam int CountW = 9;
    localparam int TotalW = 41;
    localparam int CprW   = 20;
    localparam int PosW   = 21;
    localparam int MarkW  = 8;
    localparam int DataW  = 32;
    localparam int PaddrW = 3;

    localparam logic [CprW-1:0] CprReset = 20'd50000;
    localparam logic [PaddrW-3:0] RegIdxCpr = 1'b0;
    localparam logic [MarkW-1:0] MarkMax = 8'hFF;

    // Divider: full quotient for the average, bounded quotients otherwise.
    localparam int DivW   = 41;
    localparam int GapQW  = 25;
    localparam int MarkQW = 17;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_FETCH = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SKIP = 2'd1,
        ST_OVF  = 2'd2,
        ST_FAIL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        DIV_LEN_AVG  = 2'd0,
        DIV_LEN_GAP  = 2'd1,
        DIV_LEN_MARK = 2'd2
    } t_div_len;

    typedef struct packed {
        logic            start;
        t_div_len        len;
        logic [DivW-1:0] num;
        logic [DivW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quo;
    } t_div_rsp;

endpackage

>>> rtl/fptbq_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on fptbq_pkg for the field widths.
`timescale 1ns / 1ps

interface fptbq_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     mode;
    logic [fptbq_pkg::TimeW-1:0]    pulse_time;
    logic [fptbq_pkg::ByteW-1:0]    index_zero_count;
    logic [fptbq_pkg::ByteW-1:0]    index_one_count;

    modport source (output valid, mode, pulse_time, index_zero_count, index_one_count,
                    input ready);
    modport sink (input valid, mode, pulse_time, index_zero_count, index_one_count,
                  output ready);
endinterface

interface fptbq_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [fptbq_pkg::PosW-1:0]     cell_gap;
    logic [fptbq_pkg::PosW-1:0]     cell_position;
    logic [fptbq_pkg::MarkW-1:0]    marker_value;
    logic                           last;

    modport source (output valid, status, cell_gap, cell_position, marker_value, last,
                    input ready);
    modport sink (input valid, status, cell_gap, cell_position, marker_value, last,
                  output ready);
endinterface

>>> rtl/fptbq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fptbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/fptbq_divider.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on fptbq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "flux_pulse_to_bitcell_quantizer_macros.svh"

module fptbq_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fptbq_pkg::t_div_req i_req,
    output fptbq_pkg::t_div_rsp o_rsp
);

    localparam int W    = fptbq_pkg::DivW;
    localparam int CntW = $clog2(W + 1);

    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_den;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [W-1:0]    n_rem;
    logic [W-1:0]    n_quo;
    logic [W-1:0]    n_den;
    logic [CntW-1:0] n_cnt;
    logic            n_busy;
    logic            n_done;

    logic [W:0]   shifted;
    logic [W+1:0] diff;
    logic         fits;

    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign fits    = ~diff[W+1];

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_den  = i_req.den;
            n_busy = 1'b1;
            unique case (i_req.len)
                fptbq_pkg::DIV_LEN_GAP: begin
                    n_rem = i_req.num >> fptbq_pkg::GapQW;
                    n_quo = i_req.num << (W - fptbq_pkg::GapQW);
                    n_cnt = CntW'(fptbq_pkg::GapQW);
                end
                fptbq_pkg::DIV_LEN_MARK: begin
                    n_rem = i_req.num >> fptbq_pkg::MarkQW;
                    n_quo = i_req.num << (W - fptbq_pkg::MarkQW);
                    n_cnt = CntW'(fptbq_pkg::MarkQW);
                end
                default: begin
                    n_rem = '0;
                    n_quo = i_req.num;
                    n_cnt = CntW'(W);
                end
            endcase
        end else if (r_busy) begin
            n_rem = fits ? diff[W-1:0] : shifted[W-1:0];
            n_quo = {r_quo[W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    `FPTBQ_ASSERT_IMPLIES(a_div_no_restart, i_clk, i_rst_n, i_req.start, !r_busy)
    `FPTBQ_ASSERT_IMPLIES(a_div_busy_count, i_clk, i_rst_n, r_busy, r_cnt != '0)
    `FPTBQ_ASSERT_IMPLIES(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy)

endmodule

>>> rtl/flux_pulse_to_bitcell_quantizer.sv
// Top level of the flux pulse to bit cell quantizer: pulse store, control and APB register.
// Depends on fptbq_pkg, fptbq_if, fptbq_ram, fptbq_divider and the macro header.
//
//   channel   dir  kind          payload
//   i_in      in   valid/ready   mode, pulse_time, index_zero_count, index_one_count
//   o_out     out  valid/ready   status, cell_gap, cell_position, marker_value, last
//   apb       in   APB write/rd  cells_per_revolution at byte address 0
//
// Load, clear and unused items are taken in S_IDLE and may follow back to back.
// A fetch uses the shared radix-2 divider: a 25-bit quotient for the gap and a 17-bit one
// for the marker; the first fetch of a track also divides out the 41-bit average.
// Reset is synchronous; the pulse store has no clearing pass, only entries below
// the fill count are read. A waiting result sits in the output register while
// loads and clears go on; a fetch stalls only when it must hand over its result.
`timescale 1ns / 1ps
`include "flux_pulse_to_bitcell_quantizer_macros.svh"

module flux_pulse_to_bitcell_quantizer #(
    parameter int MAX_PULSES = fptbq_pkg::MaxPulses
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fptbq_in_if.sink                      i_in,
    fptbq_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fptbq_pkg::PaddrW-1:0]  paddr,
    input  logic [fptbq_pkg::DataW-1:0]   pwdata,
    output logic [fptbq_pkg::DataW-1:0]   prdata,
    output logic                          pready
);

    localparam int AddrW  = $clog2(MAX_PULSES);
    localparam int CntW   = $clog2(MAX_PULSES + 1);
    localparam int TimeW  = fptbq_pkg::TimeW;
    localparam int IcW    = fptbq_pkg::CountW;
    localparam int TotW   = fptbq_pkg::TotalW;
    localparam int PosW   = fptbq_pkg::PosW;
    localparam int CprW   = fptbq_pkg::CprW;
    localparam int MarkW  = fptbq_pkg::MarkW;
    localparam int GapW   = fptbq_pkg::GapQW;
    localparam int MnumW  = fptbq_pkg::MarkQW;
    localparam int DivW   = fptbq_pkg::DivW;
    localparam int RamW   = TimeW + IcW;
    localparam int CmpW   = GapW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AVG   = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_READ  = 7'b0001000,
        S_GAP   = 7'b0010000,
        S_MARK  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [CprW-1:0]        r_cpr, n_cpr;
    logic [CntW-1:0]        r_pulse_count, n_pulse_count;
    logic [TotW-1:0]        r_total, n_total;
    logic [IcW-1:0]         r_max, n_max;
    logic [TotW-1:0]        r_avg, n_avg;
    logic                   r_avg_valid, n_avg_valid;
    logic [CntW-1:0]        r_rp, n_rp;
    logic [PosW-1:0]        r_pos, n_pos;
    logic                   r_failed, n_failed;
    fptbq_pkg::t_status     r_fail_status, n_fail_status;

    logic [IcW-1:0]         r_ic, n_ic;
    logic [PosW-1:0]        r_gap, n_gap;
    logic                   r_last, n_last;
    fptbq_pkg::t_status     r_res_status, n_res_status;
    logic [PosW-1:0]        r_res_gap, n_res_gap;
    logic [PosW-1:0]        r_res_pos, n_res_pos;
    logic [MarkW-1:0]       r_res_mark, n_res_mark;
    logic                   r_res_last, n_res_last;

    logic                   r_o_valid, n_o_valid;
    fptbq_pkg::t_status     r_o_status, n_o_status;
    logic [PosW-1:0]        r_o_gap, n_o_gap;
    logic [PosW-1:0]        r_o_pos, n_o_pos;
    logic [MarkW-1:0]       r_o_mark, n_o_mark;
    logic                   r_o_last, n_o_last;

    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [RamW-1:0]        ram_wr_data;
    logic [RamW-1:0]        ram_rd_data;

    fptbq_pkg::t_div_req    div_req;
    fptbq_pkg::t_div_rsp    div_rsp;

    logic                   cfg_wr;
    logic [IcW-1:0]         cnt_sum;
    logic [TotW:0]          tot_sum;
    logic                   full;
    logic [GapW-1:0]        gap_q;
    logic [CmpW-1:0]        npos;
    logic [CmpW-1:0]        pos_lim;
    logic                   gap_last;
    logic [MnumW-1:0]       mark_num;
    logic [MarkW-1:0]       mark_q;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign prdata  = (paddr[fptbq_pkg::PaddrW-1:2] == fptbq_pkg::RegIdxCpr)
                   ? {{(fptbq_pkg::DataW - CprW){1'b0}}, r_cpr} : '0;

    assign i_in.ready = (r_state == S_IDLE);

    assign cnt_sum = {1'b0, i_in.index_zero_count} + {1'b0, i_in.index_one_count};
    assign tot_sum = {1'b0, r_total} + (TotW + 1)'(i_in.pulse_time);
    assign full    = (r_pulse_count == CntW'(MAX_PULSES));
    assign ram_wr_data = {i_in.pulse_time, cnt_sum};

    assign gap_q    = div_rsp.quo[GapW-1:0];
    assign npos     = CmpW'(r_pos) + CmpW'(gap_q);
    assign pos_lim  = CmpW'({r_cpr, 1'b0});
    assign gap_last = (r_rp == r_pulse_count);
    assign mark_num = {r_ic, {MarkW{1'b0}}} - MnumW'(r_ic);
    assign mark_q   = (div_rsp.quo[DivW-1:MarkW] != '0) ? fptbq_pkg::MarkMax
                    : div_rsp.quo[MarkW-1:0];

    always_comb begin
        n_state       = r_state;
        n_cpr         = r_cpr;
        n_pulse_count = r_pulse_count;
        n_total       = r_total;
        n_max         = r_max;
        n_avg         = r_avg;
        n_avg_valid   = r_avg_valid;
        n_rp          = r_rp;
        n_pos         = r_pos;
        n_failed      = r_failed;
        n_fail_status = r_fail_status;
        n_ic          = r_ic;
        n_gap         = r_gap;
        n_last        = r_last;
        n_res_status  = r_res_status;
        n_res_gap     = r_res_gap;
        n_res_pos     = r_res_pos;
        n_res_mark    = r_res_mark;
        n_res_last    = r_res_last;
        n_o_valid     = r_o_valid & ~o_out.ready;
        n_o_status    = r_o_status;
        n_o_gap       = r_o_gap;
        n_o_pos       = r_o_pos;
        n_o_mark      = r_o_mark;
        n_o_last      = r_o_last;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        div_req.start = 1'b0;
        div_req.len   = fptbq_pkg::DIV_LEN_AVG;
        div_req.num   = r_total;
        div_req.den   = DivW'(r_cpr);

        if (cfg_wr && paddr[fptbq_pkg::PaddrW-1:2] == fptbq_pkg::RegIdxCpr) begin
            n_cpr = pwdata[CprW-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (fptbq_pkg::t_mode'(i_in.mode))
                        fptbq_pkg::MODE_LOAD: begin
                            if (!full) begin
                                ram_wr_en     = 1'b1;
                                n_pulse_count = r_pulse_count + 1'b1;
                                n_total       = tot_sum[TotW] ? '1 : tot_sum[TotW-1:0];
                                if (cnt_sum > r_max) begin
                                    n_max = cnt_sum;
                                end
                            end
                        end
                        fptbq_pkg::MODE_FETCH: begin
                            if (r_failed) begin
                                n_res_status = r_fail_status;
                                n_res_gap    = '0;
                                n_res_pos    = r_pos;
                                n_res_mark   = '0;
                                n_res_last   = 1'b0;
                                n_state      = S_OUT;
                            end else if (r_avg_valid) begin
                                n_state = S_CHECK;
                            end else if (r_cpr == '0) begin
                                n_avg       = '0;
                                n_avg_valid = 1'b1;
                                n_state     = S_CHECK;
                            end else begin
                                div_req.start = 1'b1;
                                n_state       = S_AVG;
                            end
                        end
                        fptbq_pkg::MODE_CLEAR: begin
                            n_pulse_count = '0;
                            n_total       = '0;
                            n_max         = IcW'(1);
                            n_avg         = '0;
                            n_avg_valid   = 1'b0;
                            n_rp          = '0;
                            n_pos         = '0;
                            n_failed      = 1'b0;
                            n_fail_status = fptbq_pkg::ST_OK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_AVG: begin
                if (div_rsp.done) begin
                    n_avg       = div_rsp.quo;
                    n_avg_valid = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res_gap  = '0;
                n_res_pos  = r_pos;
                n_res_mark = '0;
                if (r_avg == '0 || r_pulse_count == '0) begin
                    n_failed      = 1'b1;
                    n_fail_status = fptbq_pkg::ST_FAIL;
                    n_res_status  = fptbq_pkg::ST_FAIL;
                    n_res_last    = 1'b0;
                    n_state       = S_OUT;
                end else if (r_rp >= r_pulse_count) begin
                    n_res_status = fptbq_pkg::ST_FAIL;
                    n_res_last   = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    ram_rd_en = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                div_req.start = 1'b1;
                div_req.len   = fptbq_pkg::DIV_LEN_GAP;
                div_req.num   = DivW'(ram_rd_data[RamW-1:IcW]) + DivW'(r_avg[TotW-1:1]);
                div_req.den   = r_avg;
                n_ic          = ram_rd_data[IcW-1:0];
                n_rp          = r_rp + 1'b1;
                n_state       = S_GAP;
            end
            S_GAP: begin
                if (div_rsp.done) begin
                    n_last     = gap_last;
                    n_res_gap  = '0;
                    n_res_pos  = r_pos;
                    n_res_mark = '0;
                    n_res_last = gap_last;
                    if (gap_q == '0) begin
                        n_res_status = fptbq_pkg::ST_SKIP;
                        n_state      = S_OUT;
                    end else if (npos >= pos_lim) begin
                        n_failed      = 1'b1;
                        n_fail_status = fptbq_pkg::ST_OVF;
                        n_res_status  = fptbq_pkg::ST_OVF;
                        n_state       = S_OUT;
                    end else begin
                        n_pos         = npos[PosW-1:0];
                        n_gap         = gap_q[PosW-1:0];
                        div_req.start = 1'b1;
                        div_req.len   = fptbq_pkg::DIV_LEN_MARK;
                        div_req.num   = DivW'(mark_num);
                        div_req.den   = DivW'(r_max);
                        n_state       = S_MARK;
                    end
                end
            end
            S_MARK: begin
                if (div_rsp.done) begin
                    n_res_status = fptbq_pkg::ST_OK;
                    n_res_gap    = r_gap;
                    n_res_pos    = r_pos;
                    n_res_mark   = mark_q;
                    n_res_last   = r_last;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_gap    = r_res_gap;
                    n_o_pos    = r_res_pos;
                    n_o_mark   = r_res_mark;
                    n_o_last   = r_res_last;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cpr         <= fptbq_pkg::CprReset;
            r_pulse_count <= '0;
            r_total       <= '0;
            r_max         <= IcW'(1);
            r_avg         <= '0;
            r_avg_valid   <= 1'b0;
            r_rp          <= '0;
            r_pos         <= '0;
            r_failed      <= 1'b0;
            r_fail_status <= fptbq_pkg::ST_OK;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cpr         <= n_cpr;
            r_pulse_count <= n_pulse_count;
            r_total       <= n_total;
            r_max         <= n_max;
            r_avg         <= n_avg;
            r_avg_valid   <= n_avg_valid;
            r_rp          <= n_rp;
            r_pos         <= n_pos;
            r_failed      <= n_failed;
            r_fail_status <= n_fail_status;
            r_o_valid     <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ic         <= n_ic;
        r_gap        <= n_gap;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_gap    <= n_res_gap;
        r_res_pos    <= n_res_pos;
        r_res_mark   <= n_res_mark;
        r_res_last   <= n_res_last;
        r_o_status   <= n_o_status;
        r_o_gap      <= n_o_gap;
        r_o_pos      <= n_o_pos;
        r_o_mark     <= n_o_mark;
        r_o_last     <= n_o_last;
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.status        = r_o_status;
    assign o_out.cell_gap      = r_o_gap;
    assign o_out.cell_position = r_o_pos;
    assign o_out.marker_value  = r_o_mark;
    assign o_out.last          = r_o_last;

    fptbq_ram #(
        .WIDTH (RamW),
        .DEPTH (MAX_PULSES)
    ) u_pulse_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_pulse_count[AddrW-1:0]),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rp[AddrW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    fptbq_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    `FPTBQ_ASSERT_HOLDS(a_rp_in_range, i_clk, i_rst_n, r_rp <= r_pulse_count)
    `FPTBQ_ASSERT_HOLDS(a_max_nonzero, i_clk, i_rst_n, r_max != '0)
    `FPTBQ_ASSERT_IMPLIES(a_read_valid_entry, i_clk, i_rst_n, r_state == S_READ, r_rp < r_pulse_count)
    `FPTBQ_ASSERT_IMPLIES(a_fail_code, i_clk, i_rst_n, $rose(r_failed), r_fail_status == fptbq_pkg::ST_OVF || r_fail_status == fptbq_pkg::ST_FAIL)

endmodule

>>> verif/flux_pulse_to_bitcell_quantizer_tb.sv
// Self-checking testbench for flux_pulse_to_bitcell_quantizer: a directed table,
// a pressure phase and random tracks, checked by a predictor.
// Depends on fptbq_pkg, the fptbq_if channel interfaces and the RTL of the block.
`timescale 1ns / 1ps

module flux_pulse_to_bitcell_quantizer_tb;

    localparam logic [fptbq_pkg::CprW-1:0]   CprMax       = 20'hFFFFF;
    localparam logic [fptbq_pkg::PaddrW-1:0] CprAddr      = {fptbq_pkg::RegIdxCpr, 2'b00};
    localparam int                           HoldCycles   = 400;
    localparam int                           SettleCycles = 120;
    localparam int                           DrainLimit   = 100000;
    localparam int                           RandomItems  = 360;
    localparam int                           PrintLimit   = 50;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct packed {
        fptbq_pkg::t_mode                 mode;
        logic [fptbq_pkg::TimeW-1:0]      tm;
        logic [fptbq_pkg::ByteW-1:0]      iz;
        logic [fptbq_pkg::ByteW-1:0]      io;
    } t_pulse_item;

    typedef struct packed {
        fptbq_pkg::t_status               status;
        logic [fptbq_pkg::PosW-1:0]       gap;
        logic [fptbq_pkg::PosW-1:0]       pos;
        logic [fptbq_pkg::MarkW-1:0]      mark;
        logic                             last;
    } t_cell_result;

    typedef struct {
        t_row_kind                        kind;
        t_pulse_item                      item;
        bit                               typed;
        t_cell_result                     res;
        logic [fptbq_pkg::CprW-1:0]       cpr;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [fptbq_pkg::PaddrW-1:0] paddr;
    logic [fptbq_pkg::DataW-1:0]  pwdata;
    logic [fptbq_pkg::DataW-1:0]  prdata;
    logic                         pready;

    fptbq_in_if  in_ch ();
    fptbq_out_if out_ch ();

    flux_pulse_to_bitcell_quantizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted track state.
    logic [fptbq_pkg::TimeW-1:0]  trk_time  [fptbq_pkg::MaxPulses];
    logic [fptbq_pkg::CountW-1:0] trk_index [fptbq_pkg::MaxPulses];
    logic [16:0]                  trk_count;
    logic [fptbq_pkg::TotalW-1:0] trk_total;
    logic [fptbq_pkg::CountW-1:0] trk_max;
    logic [fptbq_pkg::TotalW-1:0] trk_avg;
    bit                           trk_avg_valid;
    logic [16:0]                  trk_rd;
    logic [fptbq_pkg::PosW-1:0]   trk_pos;
    bit                           trk_failed;
    fptbq_pkg::t_status           trk_fail_code;
    logic [fptbq_pkg::CprW-1:0]   trk_cpr;

    t_cell_result cell_results_q [$];
    t_cell_result want;
    int           mismatches;
    bit           tx_gaps_on;
    bit           rx_stalls_on;
    bit           hold_req;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_v);
        if (mismatches < PrintLimit) begin
            $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, exp_v, $time);
        end
        mismatches++;
    endtask

    function automatic void clear_track();
        trk_count     = '0;
        trk_total     = '0;
        trk_max       = 9'd1;
        trk_avg       = '0;
        trk_avg_valid = 1'b0;
        trk_rd        = '0;
        trk_pos       = '0;
        trk_failed    = 1'b0;
        trk_fail_code = fptbq_pkg::ST_OK;
    endfunction

    function automatic bit quantize_item(input t_pulse_item it, output t_cell_result r);
        logic [fptbq_pkg::CountW-1:0] cnt;
        logic [fptbq_pkg::TotalW:0]   sum;
        logic [63:0]                  gap;
        logic [63:0]                  npos;
        logic [63:0]                  mark;
        logic [fptbq_pkg::CountW-1:0] ic;
        r = '0;
        cnt = fptbq_pkg::CountW'(it.iz) + fptbq_pkg::CountW'(it.io);
        case (it.mode)
            fptbq_pkg::MODE_LOAD: begin
                if (trk_count < fptbq_pkg::MaxPulses) begin
                    trk_time[trk_count]  = it.tm;
                    trk_index[trk_count] = cnt;
                    trk_count = trk_count + 1'b1;
                    sum = {1'b0, trk_total} + (fptbq_pkg::TotalW + 1)'(it.tm);
                    trk_total = sum[fptbq_pkg::TotalW] ? {fptbq_pkg::TotalW{1'b1}}
                                                       : sum[fptbq_pkg::TotalW-1:0];
                    if (cnt > trk_max) begin
                        trk_max = cnt;
                    end
                end
                return 1'b0;
            end
            fptbq_pkg::MODE_CLEAR: begin
                clear_track();
                return 1'b0;
            end
            fptbq_pkg::MODE_NONE: return 1'b0;
            default: ;
        endcase
        r.pos = trk_pos;
        if (trk_failed) begin
            r.status = trk_fail_code;
            return 1'b1;
        end
        if (!trk_avg_valid) begin
            trk_avg = (trk_cpr != '0) ? trk_total / fptbq_pkg::TotalW'(trk_cpr) : '0;
            trk_avg_valid = 1'b1;
        end
        if (trk_avg == '0 || trk_count == '0) begin
            trk_failed = 1'b1;
            trk_fail_code = fptbq_pkg::ST_FAIL;
            r.status = fptbq_pkg::ST_FAIL;
            return 1'b1;
        end
        if (trk_rd >= trk_count) begin
            r.status = fptbq_pkg::ST_FAIL;
            r.last = 1'b1;
            return 1'b1;
        end
        ic = trk_index[trk_rd];
        gap = (64'(trk_time[trk_rd]) + 64'(trk_avg >> 1)) / 64'(trk_avg);
        trk_rd = trk_rd + 1'b1;
        r.last = (trk_rd == trk_count);
        if (gap == 0) begin
            r.status = fptbq_pkg::ST_SKIP;
            return 1'b1;
        end
        npos = 64'(trk_pos) + gap;
        if (npos >= 2 * 64'(trk_cpr)) begin
            trk_failed = 1'b1;
            trk_fail_code = fptbq_pkg::ST_OVF;
            r.status = fptbq_pkg::ST_OVF;
            return 1'b1;
        end
        trk_pos = npos[fptbq_pkg::PosW-1:0];
        mark = (64'd255 * 64'(ic)) / 64'(trk_max);
        if (mark > 255) begin
            mark = 255;
        end
        r.status = fptbq_pkg::ST_OK;
        r.gap = gap[fptbq_pkg::PosW-1:0];
        r.pos = trk_pos;
        r.mark = mark[fptbq_pkg::MarkW-1:0];
        return 1'b1;
    endfunction

    function automatic t_stim_row item_row(input fptbq_pkg::t_mode mode,
                                           input logic [fptbq_pkg::TimeW-1:0] tm,
                                           input logic [fptbq_pkg::ByteW-1:0] iz,
                                           input logic [fptbq_pkg::ByteW-1:0] io);
        t_stim_row row;
        row.kind = ROW_ITEM;
        row.item = '{mode, tm, iz, io};
        row.typed = 1'b0;
        row.res = '0;
        row.cpr = '0;
        return row;
    endfunction

    function automatic t_stim_row fetch_fixed_row(input fptbq_pkg::t_status status,
                                                  input logic [fptbq_pkg::PosW-1:0] pos,
                                                  input logic last);
        t_stim_row row;
        row = item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0);
        row.typed = 1'b1;
        row.res = '{status, '0, pos, '0, last};
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [fptbq_pkg::CprW-1:0] value);
        t_stim_row row;
        row = item_row(fptbq_pkg::MODE_NONE, '0, '0, '0);
        row.kind = ROW_CFG;
        row.cpr = value;
        return row;
    endfunction

    function automatic logic [fptbq_pkg::TimeW-1:0] pulse_interval(input int unsigned base);
        int unsigned lo;
        int unsigned hi;
        lo = base / 2;
        hi = (base > 32'h7F_FFFF) ? 32'hFF_FFFF : base * 2;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return fptbq_pkg::TimeW'($urandom);
            default: return fptbq_pkg::TimeW'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic t_pulse_item random_load(input int unsigned base);
        t_pulse_item it;
        it.mode = fptbq_pkg::MODE_LOAD;
        it.tm = pulse_interval(base);
        it.iz = ($urandom_range(0, 3) == 0) ? '0 : fptbq_pkg::ByteW'($urandom);
        it.io = ($urandom_range(0, 3) == 0) ? '0 : fptbq_pkg::ByteW'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_pulse_item it, input bit typed,
                             input t_cell_result fixed);
        int idle;
        t_cell_result r;
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            idle = $urandom_range(1, 13);
            repeat (idle) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
            end
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.mode = it.mode;
        in_ch.pulse_time = it.tm;
        in_ch.index_zero_count = it.iz;
        in_ch.index_one_count = it.io;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        if (quantize_item(it, r)) begin
            cell_results_q.push_back(typed ? fixed : r);
        end
    endtask

    task automatic wait_quiet();
        int spin;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        spin = 0;
        while (cell_results_q.size() != 0 && spin < DrainLimit) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic program_cpr(input logic [fptbq_pkg::CprW-1:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = CprAddr;
        pwdata = fptbq_pkg::DataW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (prdata !== fptbq_pkg::DataW'(value)) begin
            note_mismatch("cells_per_revolution readback", 64'(prdata), 64'(value));
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        trk_cpr = value;
    endtask

    // The receiver stalls in bursts, and once holds off for a long stretch on request.
    initial begin : result_ready_drive
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (cell_results_q.size() == 0) begin
                note_mismatch("unexpected result transfer", 64'(out_ch.cell_position), 0);
            end else begin
                want = cell_results_q.pop_front();
                if (out_ch.status !== want.status) begin
                    note_mismatch("status", 64'(out_ch.status), 64'(want.status));
                end
                if (out_ch.cell_gap !== want.gap) begin
                    note_mismatch("cell_gap", 64'(out_ch.cell_gap), 64'(want.gap));
                end
                if (out_ch.cell_position !== want.pos) begin
                    note_mismatch("cell_position", 64'(out_ch.cell_position), 64'(want.pos));
                end
                if (out_ch.marker_value !== want.mark) begin
                    note_mismatch("marker_value", 64'(out_ch.marker_value), 64'(want.mark));
                end
                if (out_ch.last !== want.last) begin
                    note_mismatch("last", 64'(out_ch.last), 64'(want.last));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_stim_row                  plan [$];
        t_pulse_item                it;
        t_cell_result               blank;
        logic [fptbq_pkg::CprW-1:0] v;
        int unsigned                base;
        int                         n;
        int                         n_pulses;
        int                         n_fetch;
        int                         late_at;
        int                         extra;
        int                         rand_sent;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = fptbq_pkg::MODE_NONE;
        in_ch.pulse_time = '0;
        in_ch.index_zero_count = '0;
        in_ch.index_one_count = '0;
        mismatches = 0;
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        hold_req = 1'b0;
        blank = '0;
        trk_cpr = fptbq_pkg::CprReset;
        clear_track();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fetches on an empty track fail and the failure latches.
        plan.push_back(fetch_fixed_row(fptbq_pkg::ST_FAIL, '0, 1'b0));
        plan.push_back(fetch_fixed_row(fptbq_pkg::ST_FAIL, '0, 1'b0));
        plan.push_back(item_row(fptbq_pkg::MODE_NONE, '1, '1, '1));
        plan.push_back(item_row(fptbq_pkg::MODE_CLEAR, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_LOAD, 24'hFF_FFFF, 8'hFF, 8'hFF));
        plan.push_back(item_row(fptbq_pkg::MODE_LOAD, 24'd0, 8'h00, 8'h00));
        plan.push_back(item_row(fptbq_pkg::MODE_LOAD, 24'd1000, 8'h00, 8'hFF));
        plan.push_back(item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0));
        // A load after the first fetch keeps the frozen average.
        plan.push_back(item_row(fptbq_pkg::MODE_LOAD, 24'd2000, 8'hFF, 8'h00));
        plan.push_back(item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0));
        // With one cell per revolution the second pulse overflows the track.
        plan.push_back(cfg_row(20'd1));
        plan.push_back(item_row(fptbq_pkg::MODE_CLEAR, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_LOAD, 24'd7, 8'h01, 8'h00));
        plan.push_back(item_row(fptbq_pkg::MODE_LOAD, 24'd7, 8'h00, 8'h01));
        plan.push_back(item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_FETCH, '0, '0, '0));
        plan.push_back(cfg_row(20'd0));
        plan.push_back(item_row(fptbq_pkg::MODE_CLEAR, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_LOAD, 24'd5000, 8'h10, 8'h20));
        plan.push_back(fetch_fixed_row(fptbq_pkg::ST_FAIL, '0, 1'b0));
        plan.push_back(cfg_row(CprMax));
        plan.push_back(item_row(fptbq_pkg::MODE_CLEAR, '0, '0, '0));
        plan.push_back(item_row(fptbq_pkg::MODE_LOAD, 24'd100, 8'h01, 8'h01));
        plan.push_back(fetch_fixed_row(fptbq_pkg::ST_FAIL, '0, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_quiet();
                program_cpr(plan[i].cpr);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].res);
            end
        end

        // The receiver holds off while fetches keep coming, so the input stalls.
        wait_quiet();
        tx_gaps_on = 1'b0;
        send_item('{fptbq_pkg::MODE_CLEAR, '0, '0, '0}, 1'b0, blank);
        repeat (10) begin
            send_item('{fptbq_pkg::MODE_LOAD, 24'd1000000, 8'h33, 8'h44}, 1'b0, blank);
        end
        hold_req = 1'b1;
        repeat (10) send_item('{fptbq_pkg::MODE_FETCH, '0, '0, '0}, 1'b0, blank);

        rand_sent = 0;
        while (rand_sent < RandomItems) begin
            if (rand_sent >= RandomItems - 60) begin
                tx_gaps_on = 1'b0;
                rx_stalls_on = 1'b0;
            end else begin
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 2) == 0) begin
                wait_quiet();
                case ($urandom_range(0, 6))
                    0: v = 20'd1;
                    1: v = CprMax;
                    2: v = 20'd0;
                    3: v = fptbq_pkg::CprW'($urandom_range(2, 64));
                    4: v = fptbq_pkg::CprReset;
                    default: v = fptbq_pkg::CprW'($urandom_range(1, 32'hFFFFF));
                endcase
                program_cpr(v);
            end
            if ($urandom_range(0, 6) == 0) begin
                n = $urandom_range(3, 12);
                repeat (n) begin
                    it.mode = fptbq_pkg::t_mode'($urandom_range(0, 3));
                    it.tm = fptbq_pkg::TimeW'($urandom);
                    it.iz = fptbq_pkg::ByteW'($urandom);
                    it.io = fptbq_pkg::ByteW'($urandom);
                    send_item(it, 1'b0, blank);
                    if (it.mode != fptbq_pkg::MODE_NONE) begin
                        rand_sent++;
                    end
                end
            end else begin
                base = 32'd1 << $urandom_range(0, 23);
                base = base | ($urandom & (base - 1));
                n_pulses = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
                send_item('{fptbq_pkg::MODE_CLEAR, '0, '0, '0}, 1'b0, blank);
                rand_sent++;
                repeat (n_pulses) begin
                    send_item(random_load(base), 1'b0, blank);
                    rand_sent++;
                end
                n_fetch = n_pulses + $urandom_range(0, 2);
                late_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_fetch - 1) : -1;
                for (int k = 0; k < n_fetch; k++) begin
                    if (k == late_at) begin
                        extra = $urandom_range(1, 3);
                        repeat (extra) begin
                            send_item(random_load(base), 1'b0, blank);
                            rand_sent++;
                        end
                    end
                    send_item('{fptbq_pkg::MODE_FETCH, '0, '0, '0}, 1'b0, blank);
                    rand_sent++;
                end
            end
        end

        wait_quiet();
        if (cell_results_q.size() != 0) begin
            note_mismatch("results never delivered", 64'(cell_results_q.size()), 0);
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
